### src/fct_pkg.sv
`default_nettype none

package fct_pkg;

  // Fixed point of the coordinates: Q.8
  localparam int CoordFrac = 8;

  // Configuration register indexes
  localparam logic [1:0] REG_ROW_X = 2'd0;
  localparam logic [1:0] REG_ROW_Y = 2'd1;
  localparam logic [1:0] REG_ROW_Z = 2'd2;
  localparam logic [1:0] REG_ROW_W = 2'd3;

  // Reset rows form the identity matrix in Q4.12 lanes
  localparam logic [63:0] ROW_X_RESET = 64'h0000_0000_0000_1000;
  localparam logic [63:0] ROW_Y_RESET = 64'h0000_0000_1000_0000;
  localparam logic [63:0] ROW_Z_RESET = 64'h0000_1000_0000_0000;
  localparam logic [63:0] ROW_W_RESET = 64'h1000_0000_0000_0000;

  // Test kind carried by the action field
  localparam logic ACT_POINT = 1'b0;
  localparam logic ACT_BOX   = 1'b1;

  // Control token that travels down the cell chain with each item
  typedef struct packed {
    logic valid;
    logic in_view;
  } fct_ctrl_t;

endpackage

`default_nettype wire

### src/fct_plane_cell.sv
`default_nettype none

module fct_plane_cell #(
  parameter int CoeffWidth = 16,
  parameter int CoordWidth = 24,
  parameter bit Sub        = 1'b0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [CoeffWidth-1:0] w_lane_i [4],
  input  logic signed [CoeffWidth-1:0] r_lane_i [4],
  input  fct_pkg::fct_ctrl_t           ctrl_i,
  input  logic signed [CoordWidth-1:0] lo_i [3],
  input  logic signed [CoordWidth-1:0] hi_i [3],
  output fct_pkg::fct_ctrl_t           ctrl_o,
  output logic signed [CoordWidth-1:0] lo_o [3],
  output logic signed [CoordWidth-1:0] hi_o [3]
);
  import fct_pkg::*;

  localparam int NormW = CoeffWidth + 1;
  localparam int ProdW = NormW + CoordWidth;
  localparam int SumW  = ProdW + 2;

  logic signed [NormW-1:0]      norm [4];
  logic signed [CoordWidth-1:0] corner [3];
  logic signed [ProdW-1:0]      prod_d [3];
  logic signed [ProdW-1:0]      prod_q [3];
  logic signed [ProdW-1:0]      cst_ext;
  logic signed [ProdW-1:0]      cst_d, cst_q;
  logic signed [CoordWidth-1:0] lo_a_q [3];
  logic signed [CoordWidth-1:0] hi_a_q [3];
  fct_ctrl_t                    ctrl_a_q;
  logic signed [SumW-1:0]       dist_sum;
  logic                         dist_neg;
  fct_ctrl_t                    ctrl_d, ctrl_q;
  logic signed [CoordWidth-1:0] lo_q [3];
  logic signed [CoordWidth-1:0] hi_q [3];

  // Plane coefficients: w row plus or minus the axis row
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (Sub) begin
        norm[k] = NormW'(w_lane_i[k]) - NormW'(r_lane_i[k]);
      end else begin
        norm[k] = NormW'(w_lane_i[k]) + NormW'(r_lane_i[k]);
      end
    end
  end

  // Take the corner furthest along the normal; zero picks the maximum
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      corner[k] = norm[k][NormW-1] ? lo_i[k] : hi_i[k];
      prod_d[k] = ProdW'(norm[k]) * ProdW'(corner[k]);
    end
    cst_ext = ProdW'(norm[3]);
    cst_d   = cst_ext <<< CoordFrac;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_a_q <= '0;
      ctrl_q   <= '0;
    end else begin
      ctrl_a_q <= ctrl_i;
      ctrl_q   <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    cst_q  <= cst_d;
    lo_a_q <= lo_i;
    hi_a_q <= hi_i;
    lo_q   <= lo_a_q;
    hi_q   <= hi_a_q;
  end

  // Exact signed distance of the chosen corner
  assign dist_sum = SumW'(prod_q[0]) + SumW'(prod_q[1]) + SumW'(prod_q[2]) + SumW'(cst_q);
  assign dist_neg = dist_sum[SumW-1];

  always_comb begin
    ctrl_d         = ctrl_a_q;
    ctrl_d.in_view = ctrl_a_q.in_view & ~dist_neg;
  end

  assign ctrl_o = ctrl_q;
  assign lo_o   = lo_q;
  assign hi_o   = hi_q;

  a_valid_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q.valid |-> $past(ctrl_i.valid, 2))
    else $error("cell output without an item two cycles earlier");

  a_inside_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_q.valid && ctrl_q.in_view) |-> $past(ctrl_i.in_view, 2))
    else $error("cell set inside on an item already outside");

  a_neg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_a_q.valid && dist_neg) |=> (ctrl_q.valid && !ctrl_q.in_view))
    else $error("negative plane distance did not clear inside");

endmodule

`default_nettype wire

### src/frustum_cull_test_unit.sv
`default_nettype none

// Frustum cull test unit. Each transfer on start_i asks whether a point
// (action_i low) or an axis-aligned box (action_i high) lies inside the six
// clip planes formed from the view-projection matrix rows: w plus and minus
// x, y and z. The unit never stalls: busy_o stays low and a new test may be
// started in every cycle. Every test gives exactly one result, a one-cycle
// pulse on done_o with inside_res_o, in start order; the receiver cannot
// hold results off, so capture them when they appear. The result passes
// through the chain of six plane cells, one per clip plane, each with a
// multiply stage and a sum-and-sign stage. Write the matrix rows (index
// 0..3 for x, y, z, w; signed Q4.12 lanes, column c at bit CoeffWidth*c)
// only while no test is in flight. Reset loads identity.
module frustum_cull_test_unit #(
  parameter int CoeffWidth = 16,
  parameter int CoordWidth = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [63:0]                  cfg_data_i,
  // test command
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         action_i,
  input  logic signed [CoordWidth-1:0] point_x_i,
  input  logic signed [CoordWidth-1:0] point_y_i,
  input  logic signed [CoordWidth-1:0] point_z_i,
  input  logic signed [CoordWidth-1:0] box_low_x_i,
  input  logic signed [CoordWidth-1:0] box_low_y_i,
  input  logic signed [CoordWidth-1:0] box_low_z_i,
  input  logic signed [CoordWidth-1:0] box_high_x_i,
  input  logic signed [CoordWidth-1:0] box_high_y_i,
  input  logic signed [CoordWidth-1:0] box_high_z_i,
  // result
  output logic                         done_o,
  output logic                         inside_res_o
);
  import fct_pkg::*;

  localparam int NumPlanes = 6;
  localparam int Latency   = 2 * NumPlanes;
  localparam int LaneSpan  = 4 * CoeffWidth;

  logic [63:0] row_q [4];

  // Lanes of each row; bits past the 64-bit register read as zero
  logic [LaneSpan-1:0]         row_ext [4];
  logic signed [CoeffWidth-1:0] lane [4][4];

  fct_ctrl_t                    ctrl_c [NumPlanes+1];
  logic signed [CoordWidth-1:0] lo_c [NumPlanes+1][3];
  logic signed [CoordWidth-1:0] hi_c [NumPlanes+1][3];
  logic                         accept;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= ROW_X_RESET;
      row_q[1] <= ROW_Y_RESET;
      row_q[2] <= ROW_Z_RESET;
      row_q[3] <= ROW_W_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROW_X: row_q[0] <= cfg_data_i;
        REG_ROW_Y: row_q[1] <= cfg_data_i;
        REG_ROW_Z: row_q[2] <= cfg_data_i;
        REG_ROW_W: row_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    if (LaneSpan > 64) begin : g_pad
      assign row_ext[r] = {{(LaneSpan-64){1'b0}}, row_q[r]};
    end else begin : g_cut
      assign row_ext[r] = row_q[r][LaneSpan-1:0];
    end
    for (genvar c = 0; c < 4; c++) begin : g_lane
      assign lane[r][c] = row_ext[r][c*CoeffWidth +: CoeffWidth];
    end
  end

  // No stall anywhere: take a command in every cycle
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Fold the point test into the box test: a point is a box of zero size
  always_comb begin
    ctrl_c[0].valid   = accept;
    ctrl_c[0].in_view = 1'b1;
    if (action_i == ACT_BOX) begin
      lo_c[0][0] = box_low_x_i;
      lo_c[0][1] = box_low_y_i;
      lo_c[0][2] = box_low_z_i;
      hi_c[0][0] = box_high_x_i;
      hi_c[0][1] = box_high_y_i;
      hi_c[0][2] = box_high_z_i;
    end else begin
      lo_c[0][0] = point_x_i;
      lo_c[0][1] = point_y_i;
      lo_c[0][2] = point_z_i;
      hi_c[0][0] = point_x_i;
      hi_c[0][1] = point_y_i;
      hi_c[0][2] = point_z_i;
    end
  end

  // One cell per clip plane; plane p uses axis p/2, minus for odd p
  for (genvar p = 0; p < NumPlanes; p++) begin : g_plane
    fct_plane_cell #(
      .CoeffWidth(CoeffWidth),
      .CoordWidth(CoordWidth),
      .Sub       (p % 2 == 1)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .w_lane_i(lane[3]),
      .r_lane_i(lane[p/2]),
      .ctrl_i  (ctrl_c[p]),
      .lo_i    (lo_c[p]),
      .hi_i    (hi_c[p]),
      .ctrl_o  (ctrl_c[p+1]),
      .lo_o    (lo_c[p+1]),
      .hi_o    (hi_c[p+1])
    );
  end

  // Present the result for one cycle at the end of the chain
  assign done_o       = ctrl_c[NumPlanes].valid;
  assign inside_res_o = ctrl_c[NumPlanes].in_view;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("accepted test gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> ##Latency !done_o)
    else $error("result without an accepted test");

endmodule

`default_nettype wire

### tb/sv/frustum_cull_test_unit_test.sv
module frustum_cull_test_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fct_pkg::*;

  localparam int CW              = 24;
  localparam int PHASE_COUNT     = 12;
  localparam int ITEMS_PER_PHASE = 92;
  localparam int SETTLE_CYCLES   = 20;
  localparam int LIMIT_CYCLES    = 200000;
  localparam int NO_PIN          = -1;

  // Matrix rows, index by register code (REG_ROW_W is the top slot).
  typedef logic [3:0][63:0] matrix_t;

  localparam matrix_t MATRIX_RESET = {ROW_W_RESET, ROW_Z_RESET, ROW_Y_RESET, ROW_X_RESET};
  localparam logic [1:0] ROW_IDX [4] = '{REG_ROW_X, REG_ROW_Y, REG_ROW_Z, REG_ROW_W};

  // One cull request as it sits on the command ports.
  typedef struct packed {
    logic                    act;
    logic [2:0][CW-1:0]      pt;
    logic [2:0][CW-1:0]      lo;
    logic [2:0][CW-1:0]      hi;
  } cull_item_t;

  // Directed row: coordinates in Q.8 as plain integers, plus the answer
  // read straight off the identity matrix (inside means every axis in [-1, 1]).
  typedef struct {
    logic act;
    int   px, py, pz;
    int   lx, ly, lz;
    int   hx, hy, hz;
    int   want;
  } cull_case_t;

  typedef enum int {
    ROWS_IDENT, ROWS_DIAG, ROWS_RANDOM, ROWS_ONES, ROWS_ZERO, ROWS_EXTREME, ROWS_FLAT
  } row_kind_e;

  localparam row_kind_e PHASE_PLAN [PHASE_COUNT] = '{
    ROWS_IDENT, ROWS_DIAG, ROWS_RANDOM, ROWS_ONES, ROWS_ZERO, ROWS_EXTREME,
    ROWS_FLAT, ROWS_DIAG, ROWS_EXTREME, ROWS_RANDOM, ROWS_FLAT, ROWS_DIAG
  };

  localparam int CMAX = 8388607;
  localparam int CMIN = -8388608;

  // Identity matrix after reset: a point is inside when each coordinate lies in
  // [-256, 256]; a box passes when on each axis hi >= -256 and lo <= 256.
  cull_case_t directed_cases [17] = '{
    '{ACT_POINT,    0,    0,    0,    0,    0,    0,    0,    0,    0, 1},
    '{ACT_POINT,  256,  256,  256,    0,    0,    0,    0,    0,    0, 1},
    '{ACT_POINT, -256, -256, -256,    0,    0,    0,    0,    0,    0, 1},
    '{ACT_POINT,  257,    0,    0,    0,    0,    0,    0,    0,    0, 0},
    '{ACT_POINT,    0, -257,    0,    0,    0,    0,    0,    0,    0, 0},
    '{ACT_POINT,    0,    0, -257,    0,    0,    0,    0,    0,    0, 0},
    '{ACT_POINT, CMAX, CMAX, CMAX,    0,    0,    0,    0,    0,    0, 0},
    '{ACT_POINT, CMIN, CMIN, CMIN,    0,    0,    0,    0,    0,    0, 0},
    // point test with the box fields at their extremes: box fields are ignored
    '{ACT_POINT,    0,    0,    0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1},
    '{ACT_BOX,      0,    0,    0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1},
    '{ACT_BOX,      0,    0,    0,  300,    0,    0,  400,    0,    0, 0},
    '{ACT_BOX,      0,    0,    0,    0,    0,    0,    0,    0, -300, 0},
    // box test with the point far outside: point fields are ignored
    '{ACT_BOX,   CMAX, CMIN, CMAX,    0,    0,    0,    0,    0,    0, 1},
    // inverted boxes: corners taken as given
    '{ACT_BOX,      0,    0,    0,  256,  256,  256, -256, -256, -256, 1},
    '{ACT_BOX,      0,    0,    0,  257,    0,    0, -300,    0,    0, 0},
    '{ACT_BOX,      0,    0,    0, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 0},
    '{ACT_BOX,      0,    0,    0, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 0}
  };

  logic          clk_i;
  logic          rst_ni       = 1'b0;
  logic          cfg_we_i     = 1'b0;
  logic [1:0]    cfg_idx_i    = REG_ROW_X;
  logic [63:0]   cfg_data_i   = '0;
  logic          start_i      = 1'b0;
  logic          busy_o;
  logic          action_i     = ACT_POINT;
  logic [CW-1:0] point_x_i    = '0;
  logic [CW-1:0] point_y_i    = '0;
  logic [CW-1:0] point_z_i    = '0;
  logic [CW-1:0] box_low_x_i  = '0;
  logic [CW-1:0] box_low_y_i  = '0;
  logic [CW-1:0] box_low_z_i  = '0;
  logic [CW-1:0] box_high_x_i = '0;
  logic [CW-1:0] box_high_y_i = '0;
  logic [CW-1:0] box_high_z_i = '0;
  logic          done_o;
  logic          inside_res_o;

  // Answer typed in by the directed table for the item on the ports, if any.
  int            pinned_want  = NO_PIN;

  matrix_t       matrix_rows  = MATRIX_RESET;
  logic          inside_fifo [$];
  int            mismatches   = 0;
  int            cycle_count  = 0;
  int            items_sent   = 0;

  frustum_cull_test_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .action_i     (action_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .box_low_x_i  (box_low_x_i),
    .box_low_y_i  (box_low_y_i),
    .box_low_z_i  (box_low_z_i),
    .box_high_x_i (box_high_x_i),
    .box_high_y_i (box_high_y_i),
    .box_high_z_i (box_high_z_i),
    .done_o       (done_o),
    .inside_res_o (inside_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Six clip planes: w row plus and minus each of x, y, z. Every product and
  // sum is exact in 64 bits (17-bit normal times 24-bit coordinate), so the
  // sign of the plain sum decides. A box uses its furthest corner per plane:
  // minimum where the normal component is negative, maximum otherwise.
  function automatic logic cull_inside(matrix_t rows, cull_item_t it);
    longint nrm [4];
    longint coord;
    longint dist_acc;
    longint wv;
    longint rv;
    logic   in_view;
    in_view = 1'b1;
    for (int axis = 0; axis < 3; axis++) begin
      for (int s = 0; s < 2; s++) begin
        for (int k = 0; k < 4; k++) begin
          wv = longint'($signed(rows[REG_ROW_W][16*k +: 16]));
          rv = longint'($signed(rows[axis][16*k +: 16]));
          nrm[k] = s ? wv - rv : wv + rv;
        end
        dist_acc = nrm[3] * (longint'(1) << CoordFrac);
        for (int k = 0; k < 3; k++) begin
          if (it.act == ACT_BOX) begin
            coord = (nrm[k] < 0) ? longint'($signed(it.lo[k])) : longint'($signed(it.hi[k]));
          end else begin
            coord = longint'($signed(it.pt[k]));
          end
          dist_acc += nrm[k] * coord;
        end
        if (dist_acc < 0) in_view = 1'b0;
      end
    end
    return in_view;
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    int            w;
    logic [CW-1:0] v;
    case ($urandom_range(0, 9))
      0: v = CW'(CMAX);
      1: v = CW'(CMIN);
      2, 3, 4, 5: v = CW'($urandom_range(0, 2047)) - CW'(1024);
      default: begin
        // random magnitude: keep w low bits, sign-extend the rest
        w = $urandom_range(1, CW);
        v = CW'($urandom);
        v = v << (CW - w);
        v = $signed(v) >>> (CW - w);
      end
    endcase
    return v;
  endfunction

  function automatic cull_item_t rand_item();
    cull_item_t    it;
    logic [CW-1:0] t;
    it.act = 1'($urandom_range(0, 1));
    for (int k = 0; k < 3; k++) begin
      it.pt[k] = rand_coord();
      it.lo[k] = rand_coord();
      it.hi[k] = rand_coord();
      // mostly well-formed boxes; leave some inverted
      if ($urandom_range(0, 99) < 85 && $signed(it.lo[k]) > $signed(it.hi[k])) begin
        t = it.lo[k];
        it.lo[k] = it.hi[k];
        it.hi[k] = t;
      end
    end
    return it;
  endfunction

  function automatic logic [15:0] small_lane();
    return 16'($urandom_range(0, 1024)) - 16'd512;
  endfunction

  function automatic logic [15:0] extreme_lane();
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  function automatic matrix_t build_rows(row_kind_e kind);
    matrix_t     m;
    logic [15:0] d;
    m = MATRIX_RESET;
    case (kind)
      ROWS_IDENT: m = MATRIX_RESET;
      ROWS_RANDOM: begin
        for (int r = 0; r < 4; r++) m[r] = {$urandom, $urandom};
      end
      ROWS_ONES: m = '1;
      ROWS_ZERO: m = '0;
      ROWS_EXTREME: begin
        for (int r = 0; r < 4; r++) begin
          for (int k = 0; k < 4; k++) m[r][16*k +: 16] = extreme_lane();
        end
      end
      ROWS_DIAG: begin
        // scaled projection-like matrix with small off-diagonal terms
        for (int r = 0; r < 4; r++) begin
          for (int k = 0; k < 4; k++) m[r][16*k +: 16] = small_lane();
        end
        for (int r = 0; r < 3; r++) begin
          d = 16'($urandom_range(256, 32767));
          if ($urandom_range(0, 3) == 0) d = -d;
          m[r][16*r +: 16] = d;
        end
        m[REG_ROW_W][48 +: 16] = 16'($urandom_range(1, 32767));
      end
      ROWS_FLAT: begin
        // x, y, z share the w normal: w minus row has a zero-length normal and
        // only the constant difference decides
        m[REG_ROW_W] = {$urandom, $urandom};
        for (int r = 0; r < 3; r++) begin
          m[r] = m[REG_ROW_W];
          m[r][48 +: 16] = 16'($urandom);
        end
      end
      default: m = MATRIX_RESET;
    endcase
    return m;
  endfunction

  task automatic report_mismatch(string what, logic want, logic got);
    $display("%0t ns: inside_res %s: want %0b got %0b", $realtime, what, want, got);
    mismatches++;
  endtask

  // Hold the request on the ports until a transfer takes it.
  task automatic drive_item(cull_item_t it, int want);
    @(negedge clk_i);
    action_i     = it.act;
    point_x_i    = it.pt[0];
    point_y_i    = it.pt[1];
    point_z_i    = it.pt[2];
    box_low_x_i  = it.lo[0];
    box_low_y_i  = it.lo[1];
    box_low_z_i  = it.lo[2];
    box_high_x_i = it.hi[0];
    box_high_y_i = it.hi[1];
    box_high_z_i = it.hi[2];
    pinned_want  = want;
    start_i      = 1'b1;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Drop start for a random gap; rate depends on how far the run has come.
  task automatic sender_gap();
    int pct;
    if (items_sent < 368) pct = 8;
    else if (items_sent < 736) pct = 77;
    else pct = 0;
    while ($urandom_range(0, 99) < pct) begin
      @(negedge clk_i);
      start_i = 1'b0;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start_i = 1'b0;
    while (inside_fifo.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_matrix(matrix_t m);
    for (int r = 0; r < 4; r++) begin
      @(negedge clk_i);
      start_i    = 1'b0;
      cfg_we_i   = 1'b1;
      cfg_idx_i  = ROW_IDX[r];
      cfg_data_i = m[ROW_IDX[r]];
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Track register writes, predict each accepted request, check each result.
  always @(posedge clk_i) begin
    cull_item_t seen;
    logic       want;
    if (!rst_ni) begin
      matrix_rows = MATRIX_RESET;
    end else begin
      if (cfg_we_i) matrix_rows[cfg_idx_i] = cfg_data_i;
      if (start_i && !busy_o) begin
        seen.act = action_i;
        seen.pt  = {point_z_i, point_y_i, point_x_i};
        seen.lo  = {box_low_z_i, box_low_y_i, box_low_x_i};
        seen.hi  = {box_high_z_i, box_high_y_i, box_high_x_i};
        want = (pinned_want != NO_PIN) ? pinned_want[0] : cull_inside(matrix_rows, seen);
        inside_fifo.push_back(want);
      end
      if (done_o) begin
        if (inside_fifo.size() == 0) begin
          report_mismatch("with nothing outstanding", 1'bx, inside_res_o);
        end else begin
          want = inside_fifo.pop_front();
          if (inside_res_o !== want) report_mismatch("differs", want, inside_res_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    cull_item_t it;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part runs on the identity matrix left by reset.
    foreach (directed_cases[i]) begin
      it.act = directed_cases[i].act;
      it.pt  = {CW'(directed_cases[i].pz), CW'(directed_cases[i].py), CW'(directed_cases[i].px)};
      it.lo  = {CW'(directed_cases[i].lz), CW'(directed_cases[i].ly), CW'(directed_cases[i].lx)};
      it.hi  = {CW'(directed_cases[i].hz), CW'(directed_cases[i].hy), CW'(directed_cases[i].hx)};
      sender_gap();
      drive_item(it, directed_cases[i].want);
    end

    // Random part: drain, load a new matrix, then stream requests.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_drained();
      write_matrix(build_rows(PHASE_PLAN[p]));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        sender_gap();
        drive_item(rand_item(), NO_PIN);
        items_sent++;
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && inside_fifo.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
